### sv/point_3d_transform_unit_macros.svh
// Assertion macros shared by the point transform checker.
`ifndef POINT_3D_TRANSFORM_UNIT_MACROS_SVH
`define POINT_3D_TRANSFORM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PTU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ptu_pkg.sv
// Shared types, constants and the quarter-wave sine table for the point transform unit.
package ptu_pkg;

    // Field and format widths
    localparam int COORD_WIDTH       = 32;
    localparam int ANGLE_FIELD_WIDTH = 16;
    localparam int ANGLE_BITS        = 16;
    localparam int CMD_WIDTH         = 3;
    localparam int SCALE_FRAC        = 16;
    localparam int SINE_FRAC         = 14;
    localparam int SINE_ENTRIES      = 256;

    // Derived widths
    localparam int PHASE_BITS    = ANGLE_BITS - 2;
    localparam int SINE_IDX_BITS = $clog2(SINE_ENTRIES + 1);
    localparam int TRIG_WIDTH    = SINE_FRAC + 2;
    localparam int PROD_WIDTH    = 2 * COORD_WIDTH;
    localparam int TERM_WIDTH    = COORD_WIDTH + TRIG_WIDTH;

    // Command codes
    localparam logic [CMD_WIDTH-1:0] CMD_TRANSLATE = CMD_WIDTH'(0);
    localparam logic [CMD_WIDTH-1:0] CMD_SCALE     = CMD_WIDTH'(1);
    localparam logic [CMD_WIDTH-1:0] CMD_ROT_X     = CMD_WIDTH'(2);
    localparam logic [CMD_WIDTH-1:0] CMD_ROT_Y     = CMD_WIDTH'(3);
    localparam logic [CMD_WIDTH-1:0] CMD_ROT_Z     = CMD_WIDTH'(4);

    typedef logic [1:0] lane_mode_t;

    // Lane operations: sum (shift 0), Q16.16 product, Q1.14 rotation term
    localparam lane_mode_t LANE_ADD = 2'd0;
    localparam lane_mode_t LANE_MUL = 2'd1;
    localparam lane_mode_t LANE_ROT = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [TRIG_WIDTH-1:0]  trig_t;
    typedef logic [SINE_FRAC:0]            sine_entry_t;
    typedef sine_entry_t                   sine_rom_t [0:SINE_ENTRIES];

    // Per-stage load strobes for the lane pipeline
    typedef struct packed {
        logic load3;
        logic load4;
        logic load5;
    } adv_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Table generation constants (unsigned Q2.30 series)
    localparam int          TAYLOR_FRAC  = 30;
    localparam int          TAYLOR_TERMS = 10;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

    // Build sin(i/N * pi/2) in Q1.14 by a truncated Taylor series, rounded half up
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] acc;
        for (int i = 0; i <= SINE_ENTRIES; i++)
        begin
            th   = (HALF_PI_Q30 * 64'(i) + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
            th2  = (th * th) >> TAYLOR_FRAC;
            term = th;
            acc  = th;
            for (int k = 1; k <= TAYLOR_TERMS; k++)
            begin
                term = ((term * th2) >> TAYLOR_FRAC) / 64'((2 * k) * (2 * k + 1));
                if (k[0])
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
            rom[i] = sine_entry_t'((acc + (64'd1 << (TAYLOR_FRAC - SINE_FRAC - 1)))
                                   >> (TAYLOR_FRAC - SINE_FRAC));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### sv/ptu_sincos.sv
// Sine and cosine lookup from the quarter-wave table for a binary angle.
module ptu_sincos
(
    input  logic [ptu_pkg::ANGLE_FIELD_WIDTH-1:0] angle,
    output ptu_pkg::trig_t                        sin_val,
    output ptu_pkg::trig_t                        cos_val
);

    localparam int SCALED_WIDTH = ptu_pkg::PHASE_BITS + ptu_pkg::SINE_IDX_BITS;
    localparam int IDX_WIDTH    = ptu_pkg::SINE_IDX_BITS;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    logic [1:0]                      quad;
    logic [ptu_pkg::PHASE_BITS-1:0]  phase;
    logic [SCALED_WIDTH-1:0]         scaled;
    logic [IDX_WIDTH-1:0]            idx;
    logic [IDX_WIDTH-1:0]            idx_mirror;
    ptu_pkg::trig_t                  tk;
    ptu_pkg::trig_t                  tn;

    // Split angle into quadrant and phase, scale phase to a table index
    assign quad       = angle[ptu_pkg::ANGLE_BITS-1 -: 2];
    assign phase      = angle[ptu_pkg::PHASE_BITS-1:0];
    assign scaled     = SCALED_WIDTH'(phase) * SCALED_WIDTH'(ptu_pkg::SINE_ENTRIES)
                      + (SCALED_WIDTH'(1) << (ptu_pkg::PHASE_BITS - 1));
    assign idx        = IDX_WIDTH'(scaled >> ptu_pkg::PHASE_BITS);
    assign idx_mirror = IDX_WIDTH'(ptu_pkg::SINE_ENTRIES) - idx;

    // Read the table at the index and its mirror
    assign tk = ptu_pkg::trig_t'({1'b0, ptu_pkg::SINE_ROM[idx]});
    assign tn = ptu_pkg::trig_t'({1'b0, ptu_pkg::SINE_ROM[idx_mirror]});

    // Fold the quadrant into signs
    always_comb
    begin
        case (quad)
            QUAD_FIRST:
            begin
                sin_val = tk;
                cos_val = tn;
            end
            QUAD_SECOND:
            begin
                sin_val = tn;
                cos_val = -tk;
            end
            QUAD_THIRD:
            begin
                sin_val = -tk;
                cos_val = -tn;
            end
            default:
            begin
                sin_val = -tn;
                cos_val = tk;
            end
        endcase
    end

endmodule

### sv/ptu_lane.sv
// One coordinate lane: multiply or add, sum, magnitude, round and saturate.
module ptu_lane
(
    input  logic                clk,
    input  ptu_pkg::adv_t       adv,
    input  ptu_pkg::lane_mode_t mode,
    input  ptu_pkg::coord_t     opa,
    input  ptu_pkg::coord_t     opb,
    input  ptu_pkg::coord_t     opc,
    input  ptu_pkg::trig_t      sinv,
    output ptu_pkg::coord_t     result,
    output logic                clipped
);

    localparam int PW = ptu_pkg::PROD_WIDTH;
    localparam int TW = ptu_pkg::TERM_WIDTH;
    localparam int CW = ptu_pkg::COORD_WIDTH;

    localparam logic [PW-1:0] SIGN_MAG = PW'(1) << (CW - 1);

    logic signed [PW-1:0] wide_a;
    logic signed [PW-1:0] wide_b;
    logic signed [TW-1:0] wide_c;
    logic signed [TW-1:0] wide_s;

    logic signed [PW-1:0] m0_next;
    logic signed [TW-1:0] m1_next;
    logic signed [PW-1:0] m0_s3_reg;
    logic signed [TW-1:0] m1_s3_reg;
    ptu_pkg::lane_mode_t  mode_s3_reg;

    logic signed [PW-1:0] sum;
    logic [PW-1:0]        mag_next;
    logic [PW-1:0]        mag_s4_reg;
    logic                 neg_s4_reg;
    ptu_pkg::lane_mode_t  mode_s4_reg;

    logic [PW-1:0]        rounded;
    logic [PW-1:0]        limited;
    logic                 over;
    ptu_pkg::coord_t      result_next;
    ptu_pkg::coord_t      result_reg;
    logic                 clipped_reg;

    // Stage 3: one 32x32 product or sum, plus the 32x16 sine term
    assign wide_a  = PW'(opa);
    assign wide_b  = PW'(opb);
    assign wide_c  = TW'(opc);
    assign wide_s  = TW'(sinv);
    assign m0_next = (mode == ptu_pkg::LANE_ADD) ? (wide_a + wide_b) : (wide_a * wide_b);
    assign m1_next = wide_c * wide_s;

    always_ff @(posedge clk)
    begin
        if (adv.load3)
        begin
            m0_s3_reg   <= m0_next;
            m1_s3_reg   <= m1_next;
            mode_s3_reg <= mode;
        end
    end

    // Stage 4: combine the terms and take the magnitude
    assign sum      = m0_s3_reg + PW'(m1_s3_reg);
    assign mag_next = sum[PW-1] ? (PW'(0) - sum) : sum;

    always_ff @(posedge clk)
    begin
        if (adv.load4)
        begin
            mag_s4_reg  <= mag_next;
            neg_s4_reg  <= sum[PW-1];
            mode_s4_reg <= mode_s3_reg;
        end
    end

    // Stage 5: round half away from zero, then clip to the coordinate range
    always_comb
    begin
        case (mode_s4_reg)
            ptu_pkg::LANE_MUL:
            begin
                rounded = (mag_s4_reg + (PW'(1) << (ptu_pkg::SCALE_FRAC - 1)))
                          >> ptu_pkg::SCALE_FRAC;
            end
            ptu_pkg::LANE_ROT:
            begin
                rounded = (mag_s4_reg + (PW'(1) << (ptu_pkg::SINE_FRAC - 1)))
                          >> ptu_pkg::SINE_FRAC;
            end
            default:
            begin
                rounded = mag_s4_reg;
            end
        endcase
    end

    always_comb
    begin
        if (neg_s4_reg)
        begin
            over    = (rounded > SIGN_MAG);
            limited = over ? SIGN_MAG : rounded;
        end
        else
        begin
            over    = (rounded > (SIGN_MAG - PW'(1)));
            limited = over ? (SIGN_MAG - PW'(1)) : rounded;
        end
    end

    assign result_next = neg_s4_reg ? CW'(PW'(0) - limited) : CW'(limited);

    always_ff @(posedge clk)
    begin
        if (adv.load5)
        begin
            result_reg  <= result_next;
            clipped_reg <= over;
        end
    end

    assign result  = result_reg;
    assign clipped = clipped_reg;

endmodule

### sv/point_3d_transform_unit.sv
// Affine transform of one Q16.16 3D point per transaction: translate, scale, rotate.
// Pipeline: five register stages, each holding a valid flag and its payload.
// Throughput: one transaction per cycle; each stage holds only while the stage after it is
// full and cannot move, so the input stalls only when every stage and the output are full.
// Reset: rst_n clears every stage valid flag at once; the sine table is constant logic.
module point_3d_transform_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [ptu_pkg::CMD_WIDTH-1:0]         cmd,
    input  ptu_pkg::coord_t                       point_x,
    input  ptu_pkg::coord_t                       point_y,
    input  ptu_pkg::coord_t                       point_z,
    input  ptu_pkg::coord_t                       arg_a,
    input  ptu_pkg::coord_t                       arg_b,
    input  ptu_pkg::coord_t                       arg_c,
    input  logic [ptu_pkg::ANGLE_FIELD_WIDTH-1:0] turn_angle,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output ptu_pkg::coord_t                       out_x,
    output ptu_pkg::coord_t                       out_y,
    output ptu_pkg::coord_t                       out_z,
    output logic                                  saturated
);

    localparam int LANES = 3;

    // Stage valid flags and ready chain
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic s5_valid_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    logic rdy5;

    ptu_pkg::adv_t adv;

    // Stage 1 payload
    logic [ptu_pkg::CMD_WIDTH-1:0]         cmd_s1_reg;
    ptu_pkg::coord_t                       px_s1_reg;
    ptu_pkg::coord_t                       py_s1_reg;
    ptu_pkg::coord_t                       pz_s1_reg;
    ptu_pkg::coord_t                       ka_s1_reg;
    ptu_pkg::coord_t                       kb_s1_reg;
    ptu_pkg::coord_t                       kc_s1_reg;
    logic [ptu_pkg::ANGLE_FIELD_WIDTH-1:0] angle_s1_reg;

    ptu_pkg::trig_t  sin_val;
    ptu_pkg::trig_t  cos_val;
    ptu_pkg::trig_t  sin_neg;
    ptu_pkg::coord_t cos_wide;

    // Stage 2 lane setup
    ptu_pkg::lane_mode_t mode_next [LANES];
    ptu_pkg::coord_t     opa_next  [LANES];
    ptu_pkg::coord_t     opb_next  [LANES];
    ptu_pkg::coord_t     opc_next  [LANES];
    ptu_pkg::trig_t      sinv_next [LANES];
    ptu_pkg::lane_mode_t mode_s2_reg [LANES];
    ptu_pkg::coord_t     opa_s2_reg  [LANES];
    ptu_pkg::coord_t     opb_s2_reg  [LANES];
    ptu_pkg::coord_t     opc_s2_reg  [LANES];
    ptu_pkg::trig_t      sinv_s2_reg [LANES];

    ptu_pkg::coord_t lane_result  [LANES];
    logic            lane_clipped [LANES];

    // Ready chain: a stage moves when it is empty or the next one moves
    assign rdy5     = !s5_valid_reg || !out_stall;
    assign rdy4     = !s4_valid_reg || rdy5;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_stall = !rdy1;

    assign adv.load3 = rdy3 && s2_valid_reg;
    assign adv.load4 = rdy4 && s3_valid_reg;
    assign adv.load5 = rdy5 && s4_valid_reg;

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            cmd_s1_reg   <= cmd;
            px_s1_reg    <= point_x;
            py_s1_reg    <= point_y;
            pz_s1_reg    <= point_z;
            ka_s1_reg    <= arg_a;
            kb_s1_reg    <= arg_b;
            kc_s1_reg    <= arg_c;
            angle_s1_reg <= turn_angle;
        end
    end

    ptu_sincos u_sincos
    (
        .angle   (angle_s1_reg),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    assign sin_neg  = -sin_val;
    assign cos_wide = ptu_pkg::coord_t'(cos_val);

    // Route operands to the lanes; untouched axes pass as a sum with zero
    always_comb
    begin
        mode_next[0] = ptu_pkg::LANE_ADD;
        mode_next[1] = ptu_pkg::LANE_ADD;
        mode_next[2] = ptu_pkg::LANE_ADD;
        opa_next[0]  = px_s1_reg;
        opa_next[1]  = py_s1_reg;
        opa_next[2]  = pz_s1_reg;
        opb_next[0]  = '0;
        opb_next[1]  = '0;
        opb_next[2]  = '0;
        opc_next[0]  = '0;
        opc_next[1]  = '0;
        opc_next[2]  = '0;
        sinv_next[0] = '0;
        sinv_next[1] = '0;
        sinv_next[2] = '0;
        case (cmd_s1_reg)
            ptu_pkg::CMD_TRANSLATE:
            begin
                opb_next[0] = ka_s1_reg;
                opb_next[1] = kb_s1_reg;
                opb_next[2] = kc_s1_reg;
            end
            ptu_pkg::CMD_SCALE:
            begin
                mode_next[0] = ptu_pkg::LANE_MUL;
                mode_next[1] = ptu_pkg::LANE_MUL;
                mode_next[2] = ptu_pkg::LANE_MUL;
                opb_next[0]  = ka_s1_reg;
                opb_next[1]  = kb_s1_reg;
                opb_next[2]  = kc_s1_reg;
            end
            ptu_pkg::CMD_ROT_X:
            begin
                mode_next[1] = ptu_pkg::LANE_ROT;
                opb_next[1]  = cos_wide;
                opc_next[1]  = pz_s1_reg;
                sinv_next[1] = sin_neg;
                mode_next[2] = ptu_pkg::LANE_ROT;
                opb_next[2]  = cos_wide;
                opc_next[2]  = py_s1_reg;
                sinv_next[2] = sin_val;
            end
            ptu_pkg::CMD_ROT_Y:
            begin
                mode_next[0] = ptu_pkg::LANE_ROT;
                opb_next[0]  = cos_wide;
                opc_next[0]  = pz_s1_reg;
                sinv_next[0] = sin_val;
                mode_next[2] = ptu_pkg::LANE_ROT;
                opb_next[2]  = cos_wide;
                opc_next[2]  = px_s1_reg;
                sinv_next[2] = sin_neg;
            end
            ptu_pkg::CMD_ROT_Z:
            begin
                mode_next[0] = ptu_pkg::LANE_ROT;
                opb_next[0]  = cos_wide;
                opc_next[0]  = py_s1_reg;
                sinv_next[0] = sin_neg;
                mode_next[1] = ptu_pkg::LANE_ROT;
                opb_next[1]  = cos_wide;
                opc_next[1]  = px_s1_reg;
                sinv_next[1] = sin_val;
            end
            default:
            begin
                mode_next[0] = ptu_pkg::LANE_ADD;
            end
        endcase
    end

    // Hold lane operands in stage 2
    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid_reg)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                mode_s2_reg[i] <= mode_next[i];
                opa_s2_reg[i]  <= opa_next[i];
                opb_s2_reg[i]  <= opb_next[i];
                opc_s2_reg[i]  <= opc_next[i];
                sinv_s2_reg[i] <= sinv_next[i];
            end
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        ptu_lane u_lane
        (
            .clk     (clk),
            .adv     (adv),
            .mode    (mode_s2_reg[g]),
            .opa     (opa_s2_reg[g]),
            .opb     (opb_s2_reg[g]),
            .opc     (opc_s2_reg[g]),
            .sinv    (sinv_s2_reg[g]),
            .result  (lane_result[g]),
            .clipped (lane_clipped[g])
        );
    end

    assign out_valid = s5_valid_reg;
    assign out_x     = lane_result[0];
    assign out_y     = lane_result[1];
    assign out_z     = lane_result[2];
    assign saturated = lane_clipped[0] | lane_clipped[1] | lane_clipped[2];

endmodule

### sv/ptu_checker.sv
// Port-level checker for the point transform unit, bound to the top level.
`include "point_3d_transform_unit_macros.svh"

module ptu_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_stall,
    input logic            out_valid,
    input logic            out_stall,
    input ptu_pkg::coord_t out_x,
    input ptu_pkg::coord_t out_y,
    input ptu_pkg::coord_t out_z,
    input logic            saturated
);

    // A stalled result stays offered
    `PTU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // A stalled result keeps its payload
    `PTU_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(saturated), "result changed while stalled")

    // Input stalls only when the pipeline is backed up from the output
    `PTU_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with room in pipeline")

    // A clip flag means some coordinate sits on a rail
    `PTU_ASSERT_NOW(a_sat_rail, out_valid && saturated, (out_x == ptu_pkg::COORD_MAX) || (out_x == ptu_pkg::COORD_MIN) || (out_y == ptu_pkg::COORD_MAX) || (out_y == ptu_pkg::COORD_MIN) || (out_z == ptu_pkg::COORD_MAX) || (out_z == ptu_pkg::COORD_MIN), "clip flag without a saturated coordinate")

endmodule

bind point_3d_transform_unit ptu_checker u_ptu_checker (.*);
